// File: rtl/msbr_pkg.sv
// shared types and constants for the msb-first bit reader
package msbr_pkg;

  localparam int unsigned ModeW  = 1;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;

  // largest read request that is served
  localparam logic [CountW-1:0] MaxRead = CountW'(ValueW);

  localparam logic [ModeW-1:0] ModePush = 1'b0;
  localparam logic [ModeW-1:0] ModeRead = 1'b1;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StUnder = 2'd1;
  localparam logic [StatW-1:0] StOver  = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [ByteW-1:0]  byte_in;
    logic [CountW-1:0] bit_count;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [StatW-1:0]  status;
  } result_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_BAD  = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ByteW-1:0]  byte_in;
    logic [CountW-1:0] bit_count;
  } cmd_t;

endpackage

// File: rtl/msbr_fifo.sv
// small register queue used between the stages and at the result side
module msbr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/msbr_front.sv
// front stage: turns an input beat into a command for the reservoir stage
module msbr_front (
  input  msbr_pkg::item_t item_i,
  output msbr_pkg::cmd_t  cmd_o
);
  import msbr_pkg::*;

  always_comb begin
    cmd_o.byte_in   = item_i.byte_in;
    cmd_o.bit_count = item_i.bit_count;
    case (item_i.mode)
      ModePush: cmd_o.op = OP_PUSH;
      ModeRead: cmd_o.op = (item_i.bit_count > MaxRead) ? OP_BAD : OP_READ;
      default:  cmd_o.op = OP_BAD;
    endcase
  end

endmodule

// File: rtl/msbr_back.sv
// back stage: owns the bit reservoir and produces one result per command
module msbr_back #(
  parameter int unsigned MAX_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  msbr_pkg::cmd_t    cmd_i,
  output msbr_pkg::result_t result_o
);
  import msbr_pkg::*;

  localparam int unsigned HeldW = $clog2(MAX_BITS + 1);
  localparam int unsigned SumW  = $clog2(MAX_BITS + ByteW + 1);
  localparam int unsigned CmpW  = (HeldW > CountW) ? HeldW : CountW;
  localparam int unsigned XW    = (MAX_BITS > ValueW) ? MAX_BITS : ValueW;

  logic [MAX_BITS-1:0] res_q, res_d;
  logic [HeldW-1:0]    held_q, held_d;
  logic [SumW-1:0]     sum;
  logic [HeldW-1:0]    rest;
  logic [XW-1:0]       shifted, rd_mask;
  logic                short_read;

  assign sum        = SumW'(held_q) + SumW'(ByteW);
  assign short_read = CmpW'(cmd_i.bit_count) > CmpW'(held_q);
  assign rest       = held_q - HeldW'(cmd_i.bit_count);
  assign shifted    = XW'(res_q) >> rest;
  assign rd_mask    = ~({XW{1'b1}} << cmd_i.bit_count);

  always_comb begin
    res_d           = res_q;
    held_d          = held_q;
    result_o.value  = '0;
    result_o.status = StOk;
    case (cmd_i.op)
      OP_PUSH: begin
        if (sum > SumW'(MAX_BITS)) begin
          result_o.status = StOver;
        end else begin
          // bits above held_q are always zero, so the shift drops nothing
          res_d  = (res_q << ByteW) | MAX_BITS'(cmd_i.byte_in);
          held_d = HeldW'(sum);
        end
      end
      OP_READ: begin
        if (short_read) begin
          result_o.status = StUnder;
        end else begin
          result_o.value = ValueW'(shifted & rd_mask);
          res_d          = res_q & ~({MAX_BITS{1'b1}} << rest);
          held_d         = rest;
        end
      end
      default: begin
        result_o.status = StUnder;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      held_q <= '0;
    end else if (fire_i) begin
      res_q  <= res_d;
      held_q <= held_d;
    end
  end

endmodule

// File: rtl/msb_first_bit_reader_unit.sv
// top level of the msb-first bit reader: front, command queue, reservoir stage, result queue
//
// Each input beat either pushes one stream byte into a bit reservoir of MAX_BITS bits or
// asks for the next 0 to 32 bits, oldest bit first, returned right-aligned. Every beat
// yields exactly one result beat: status ok, underflow (too few bits held, or a request
// above 32; nothing is consumed) or overflow (a push that would exceed MAX_BITS; the
// byte is dropped). The block takes one beat per cycle sustained while results are popped
// and full stays low. An accepted beat passes through the command queue, which feeds the
// combinational reservoir update (one barrel shift, one mask and one count update), whose
// result is registered in the result queue. Both sides may
// stall freely: full goes high only when the command queue is full, and results wait in
// a queue of QUEUE_DEPTH beats until popped.
module msb_first_bit_reader_unit #(
  parameter int unsigned MAX_BITS    = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input side, queue style
  input  logic              push,
  output logic              full,
  input  msbr_pkg::item_t   in_item_i,
  // result side, queue style
  output logic              empty,
  input  logic              pop,
  output msbr_pkg::result_t result_o
);
  import msbr_pkg::*;

  cmd_t    cmd_in, cmd_out;
  result_t res_in;
  logic    cmd_empty, res_full, fire;

  // classify the incoming beat
  msbr_front u_front (
    .item_i (in_item_i),
    .cmd_o  (cmd_in)
  );

  // decouples the input handshake from the reservoir stage
  msbr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (fire),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // a command executes when one waits and its result has a slot
  assign fire = !cmd_empty && !res_full;

  msbr_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .cmd_i    (cmd_out),
    .result_o (res_in)
  );

  // result beats wait here until popped
  msbr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule
